@@ hdl/fbp_pkg.sv @@
// fbp_pkg: shared types, codes and tables of the position string parser
// no dependencies
`default_nettype none

package fbp_pkg;

  typedef enum logic [2:0] {
    PH_BOARD,
    PH_SEP_A,
    PH_SIDE,
    PH_SEP_B,
    PH_CASTLE,
    PH_EP_FILE,
    PH_EP_RANK,
    PH_DONE
  } phase_t;

  localparam logic [1:0] CMD_FEED  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [6:0] NO_SQUARE  = 7'd120;
  localparam logic [3:0] OFF_BOARD  = 4'd13;
  localparam logic [3:0] EMPTY      = 4'd0;
  localparam logic [6:0] BOARD_FULL = 7'd64;
  localparam logic [1:0] SIDE_WHITE = 2'd0;
  localparam logic [1:0] SIDE_BLACK = 2'd1;
  localparam logic [1:0] SIDE_UNSET = 2'd2;
  localparam logic [3:0] CASTLE_ALL = 4'hf;

  localparam logic [3:0] W_PAWN   = 4'd1;
  localparam logic [3:0] W_KNIGHT = 4'd2;
  localparam logic [3:0] W_BISHOP = 4'd3;
  localparam logic [3:0] W_ROOK   = 4'd4;
  localparam logic [3:0] W_QUEEN  = 4'd5;
  localparam logic [3:0] W_KING   = 4'd6;
  localparam logic [3:0] B_PAWN   = 4'd7;
  localparam logic [3:0] B_OFFSET = 4'd6;

  // one access to the board store per item
  typedef struct packed {
    logic       we;
    logic [5:0] waddr;
    logic [3:0] wdata;
    logic       re;
    logic [5:0] raddr;
    logic       clr;
  } store_req_t;

  function automatic logic [3:0] letter_code(input logic [7:0] c);
    logic [3:0] code;
    case (c)
      "P": code = W_PAWN;
      "N": code = W_KNIGHT;
      "B": code = W_BISHOP;
      "R": code = W_ROOK;
      "Q": code = W_QUEEN;
      "K": code = W_KING;
      "p": code = W_PAWN + B_OFFSET;
      "n": code = W_KNIGHT + B_OFFSET;
      "b": code = W_BISHOP + B_OFFSET;
      "r": code = W_ROOK + B_OFFSET;
      "q": code = W_QUEEN + B_OFFSET;
      "k": code = W_KING + B_OFFSET;
      default: code = EMPTY;
    endcase
    return code;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic [3:0] back_rank(input logic [2:0] col);
    logic [3:0] code;
    case (col)
      3'd0, 3'd7: code = W_ROOK;
      3'd1, 3'd6: code = W_KNIGHT;
      3'd2, 3'd5: code = W_BISHOP;
      3'd3:       code = W_QUEEN;
      3'd4:       code = W_KING;
      default:    code = EMPTY;
    endcase
    return code;
  endfunction

  // standard opening position, row 0 holds the black back rank
  function automatic logic [3:0] start_piece(input logic [5:0] idx);
    logic [3:0] code;
    case (idx[5:3])
      3'd0:    code = back_rank(idx[2:0]) + B_OFFSET;
      3'd1:    code = B_PAWN;
      3'd6:    code = W_PAWN;
      3'd7:    code = back_rank(idx[2:0]);
      default: code = EMPTY;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

@@ hdl/fbp_board_store.sv @@
// fbp_board_store: 64-entry square memory with per-entry valid bits
// unwritten entries read as the opening position or as empty after a clear
// depends on fbp_pkg
`default_nettype none

module fbp_board_store (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire fbp_pkg::store_req_t req,
  output logic [3:0]              rd_piece
);
  import fbp_pkg::*;

  logic [3:0]  mem [64];
  logic [63:0] written;
  logic        cleared;
  logic [3:0]  mem_q;
  logic        written_q;
  logic        cleared_q;
  logic [3:0]  start_q;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      mem_q     <= mem[req.raddr];
      written_q <= written[req.raddr];
      cleared_q <= cleared;
      start_q   <= start_piece(req.raddr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      cleared <= 1'b0;
    end else if (req.clr) begin
      written <= '0;
      cleared <= 1'b1;
    end else if (req.we) begin
      written[req.waddr] <= 1'b1;
    end
  end

  always_comb begin
    if (written_q) begin
      rd_piece = mem_q;
    end else if (cleared_q) begin
      rd_piece = EMPTY;
    end else begin
      rd_piece = start_q;
    end
  end

endmodule

`default_nettype wire

@@ hdl/fen_board_parser.sv @@
// fen_board_parser: streaming chess position string parser, board in 0x88 numbering
// depends on fbp_pkg and fbp_board_store
//
//   channel | signals                                   | role
//   in      | command, fen_char, square_index           | characters, start, square reads
//   out     | piece_code, side_to_move, castling_rights,| one result item per input item
//           | en_passant_square, parse_done             |
//
// one item per cycle sustained while out_ready keeps the output moving; each result passes
// through the board memory read register and then through the output register
// reset restores the opening position at once through per-square valid bits, no clear pass
// a stalled result holds in the output register while one more item enters the read stage
`default_nettype none

module fen_board_parser (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] command,
  input  wire logic [7:0] fen_char,
  input  wire logic [6:0] square_index,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [3:0]      piece_code,
  output logic [1:0]      side_to_move,
  output logic [3:0]      castling_rights,
  output logic [6:0]      en_passant_square,
  output logic            parse_done
);
  import fbp_pkg::*;

  phase_t     phase, phase_next;
  logic [6:0] squares_filled, squares_filled_next;
  logic [1:0] side_reg, side_reg_next;
  logic [3:0] castle_reg, castle_reg_next;
  logic [6:0] passant_reg, passant_reg_next;
  logic [2:0] passant_file, passant_file_next;

  store_req_t req;
  logic [3:0] rd_piece;
  logic       accept;
  logic       feed;
  logic [7:0] digit_sum;
  logic [2:0] ep_row;

  logic       s1_valid, s1_read, s1_off, s1_done;
  logic [1:0] s1_side;
  logic [3:0] s1_castle;
  logic [6:0] s1_ep;
  logic       s1_move;

  assign accept  = in_valid && in_ready;
  assign feed    = accept && (command == CMD_FEED);
  assign s1_move = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || !out_valid || out_ready;

  assign digit_sum = {1'b0, squares_filled} + {4'd0, fen_char[3:0] - 4'd0};
  assign ep_row    = 3'd0 - fen_char[2:0];

  // next phase
  always_comb begin
    phase_next = phase;
    if (accept && (command == CMD_START)) begin
      phase_next = PH_BOARD;
    end else if (feed) begin
      case (phase)
        PH_BOARD: begin
          if (squares_filled_next >= BOARD_FULL) begin
            phase_next = PH_SEP_A;
          end
        end
        PH_SEP_A:   phase_next = PH_SIDE;
        PH_SIDE:    phase_next = PH_SEP_B;
        PH_SEP_B:   phase_next = PH_CASTLE;
        PH_CASTLE: begin
          if (fen_char == " ") begin
            phase_next = PH_EP_FILE;
          end
        end
        PH_EP_FILE: phase_next = (fen_char == "-") ? PH_DONE : PH_EP_RANK;
        PH_EP_RANK: phase_next = PH_DONE;
        default:    phase_next = phase;
      endcase
    end
  end

  // register updates and store access
  always_comb begin
    squares_filled_next = squares_filled;
    side_reg_next       = side_reg;
    castle_reg_next     = castle_reg;
    passant_reg_next    = passant_reg;
    passant_file_next   = passant_file;
    req.we    = 1'b0;
    req.waddr = squares_filled[5:0];
    req.wdata = letter_code(fen_char);
    req.re    = accept && (command == CMD_READ);
    req.raddr = {square_index[6:4], square_index[2:0]};
    req.clr   = 1'b0;
    if (accept && (command == CMD_START)) begin
      req.clr             = 1'b1;
      squares_filled_next = '0;
      side_reg_next       = SIDE_UNSET;
      castle_reg_next     = '0;
      passant_reg_next    = NO_SQUARE;
      passant_file_next   = '0;
    end else if (feed) begin
      case (phase)
        PH_BOARD: begin
          if (is_letter(fen_char)) begin
            req.we              = 1'b1;
            squares_filled_next = squares_filled + 7'd1;
          end else if (is_digit(fen_char)) begin
            squares_filled_next = (digit_sum > {1'b0, BOARD_FULL}) ? BOARD_FULL
                                                                    : digit_sum[6:0];
          end
        end
        PH_SIDE: begin
          side_reg_next = (fen_char == "w") ? SIDE_WHITE : SIDE_BLACK;
        end
        PH_CASTLE: begin
          case (fen_char)
            "K":     castle_reg_next = castle_reg | 4'b0001;
            "Q":     castle_reg_next = castle_reg | 4'b0010;
            "k":     castle_reg_next = castle_reg | 4'b0100;
            "q":     castle_reg_next = castle_reg | 4'b1000;
            default: castle_reg_next = castle_reg;
          endcase
        end
        PH_EP_FILE: begin
          if (fen_char == "-") begin
            passant_reg_next = NO_SQUARE;
          end else begin
            passant_file_next = fen_char[2:0] - 3'd1;
          end
        end
        PH_EP_RANK: begin
          passant_reg_next = {ep_row, 1'b0, passant_file};
        end
        default: begin
          squares_filled_next = squares_filled;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_DONE;
      squares_filled <= '0;
      side_reg       <= SIDE_WHITE;
      castle_reg     <= CASTLE_ALL;
      passant_reg    <= NO_SQUARE;
      passant_file   <= '0;
    end else begin
      phase          <= phase_next;
      squares_filled <= squares_filled_next;
      side_reg       <= side_reg_next;
      castle_reg     <= castle_reg_next;
      passant_reg    <= passant_reg_next;
      passant_file   <= passant_file_next;
    end
  end

  fbp_board_store u_store (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rd_piece (rd_piece)
  );

  // read stage, waits for the memory data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_read   <= (command == CMD_READ);
      s1_off    <= square_index[3];
      s1_side   <= side_reg_next;
      s1_castle <= castle_reg_next;
      s1_ep     <= passant_reg_next;
      s1_done   <= (phase_next == PH_DONE);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      if (!s1_read) begin
        piece_code <= EMPTY;
      end else if (s1_off) begin
        piece_code <= OFF_BOARD;
      end else begin
        piece_code <= rd_piece;
      end
      side_to_move      <= s1_side;
      castling_rights   <= s1_castle;
      en_passant_square <= s1_ep;
      parse_done        <= s1_done;
    end
  end

endmodule

`default_nettype wire

@@ hdl/fbp_checker.sv @@
// fbp_checker: port-level checks of the position string parser
// bound to fen_board_parser, depends on nothing else
`default_nettype none

module fbp_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [3:0] piece_code,
  input wire logic [1:0] side_to_move,
  input wire logic [6:0] en_passant_square
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(piece_code)
      && $stable(side_to_move) && $stable(en_passant_square))
    else $error("result item changed while stalled");

  a_piece_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> piece_code <= 4'd13)
    else $error("piece code out of range");

  a_side_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> side_to_move != 2'd3)
    else $error("side to move code out of range");

  // en passant is none or a real board square
  a_ep_square: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (en_passant_square == 7'd120) || !en_passant_square[3])
    else $error("en passant square off the board");

endmodule

bind fen_board_parser fbp_checker u_fbp_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .piece_code        (piece_code),
  .side_to_move      (side_to_move),
  .en_passant_square (en_passant_square)
);

`default_nettype wire

@@ test/tb_top.sv @@
// tb_top: self-checking bench for fen_board_parser, random handshake gaps on both channels
// directed table then random position strings and noise, every result checked in order
// depends on fbp_pkg and fen_board_parser
`timescale 1ns / 1ps

module tb_top;
  import fbp_pkg::*;

  localparam logic [1:0]  CMD_SPARE    = 2'd3;
  localparam int          IDLE_LIMIT   = 2000;
  localparam int          RANDOM_ITEMS = 1100;
  localparam int          DRAIN_CYCLES = 20;
  localparam logic [95:0] PIECE_CHARS  = "PNBRQKpnbrqk";
  localparam logic [31:0] CASTLE_CHARS = "KQkq";
  localparam logic [13:0] AT_RESET     = {SIDE_WHITE, CASTLE_ALL, NO_SQUARE, 1'b1};

  typedef struct packed {
    logic [3:0] piece;
    logic [1:0] side;
    logic [3:0] castle;
    logic [6:0] ep;
    logic       done;
  } board_result_t;

  typedef struct {
    logic [1:0]    cmd;
    logic [7:0]    ch;
    logic [6:0]    sq;
    int            reps;
    logic          typed;
    board_result_t want;
  } stim_row_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] command;
  logic [7:0] fen_char;
  logic [6:0] square_index;
  logic       out_valid;
  logic       out_ready;
  logic [3:0] piece_code;
  logic [1:0] side_to_move;
  logic [3:0] castling_rights;
  logic [6:0] en_passant_square;
  logic       parse_done;

  // predictor state
  logic [3:0] board [64];
  logic [6:0] filled;
  phase_t     phase;
  logic [1:0] side;
  logic [3:0] castle;
  logic [6:0] passant;
  logic [2:0] pfile;

  board_result_t result_q [$];
  stim_row_t     plan [$];
  board_result_t row_want;
  board_result_t predicted;
  board_result_t want;
  logic          row_typed;
  int            errors;
  int            items_sent;
  int            burst_left;
  int            idle_cycles;

  fen_board_parser dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .command           (command),
    .fen_char          (fen_char),
    .square_index      (square_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .piece_code        (piece_code),
    .side_to_move      (side_to_move),
    .castling_rights   (castling_rights),
    .en_passant_square (en_passant_square),
    .parse_done        (parse_done)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic board_result_t board_step(input logic [1:0] cmd, input logic [7:0] ch,
                                               input logic [6:0] sq);
    board_result_t res;
    logic [7:0]    span;
    logic [3:0]    code;
    res = '0;
    case (cmd)
      CMD_FEED: begin
        case (phase)
          PH_BOARD: begin
            if ((ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z")) begin
              code = EMPTY;
              for (int i = 0; i < 12; i++) begin
                if (PIECE_CHARS[8*(11-i) +: 8] == ch) code = 4'(i + 1);
              end
              board[filled[5:0]] = code;
              filled = filled + 7'd1;
            end else if (ch >= "0" && ch <= "9") begin
              span = 8'(filled) + (ch - "0");
              filled = (span > 8'(BOARD_FULL)) ? BOARD_FULL : span[6:0];
            end
            if (filled >= BOARD_FULL) phase = PH_SEP_A;
          end
          PH_SEP_A: phase = PH_SIDE;
          PH_SIDE: begin
            side = (ch == "w") ? SIDE_WHITE : SIDE_BLACK;
            phase = PH_SEP_B;
          end
          PH_SEP_B: phase = PH_CASTLE;
          PH_CASTLE: begin
            if (ch == " ") phase = PH_EP_FILE;
            else if (ch == "K") castle[0] = 1'b1;
            else if (ch == "Q") castle[1] = 1'b1;
            else if (ch == "k") castle[2] = 1'b1;
            else if (ch == "q") castle[3] = 1'b1;
          end
          PH_EP_FILE: begin
            if (ch == "-") begin
              passant = NO_SQUARE;
              phase = PH_DONE;
            end else begin
              span = ch - "a";
              pfile = span[2:0];
              phase = PH_EP_RANK;
            end
          end
          PH_EP_RANK: begin
            span = 8'd8 - (ch - "0");
            passant = {span[2:0], 1'b0, pfile};
            phase = PH_DONE;
          end
          default: ;
        endcase
      end
      CMD_START: begin
        for (int i = 0; i < 64; i++) board[i] = EMPTY;
        filled = '0;
        phase = PH_BOARD;
        side = SIDE_UNSET;
        castle = '0;
        passant = NO_SQUARE;
        pfile = '0;
      end
      CMD_READ: res.piece = sq[3] ? OFF_BOARD : board[{sq[6:4], sq[2:0]}];
      default: ;
    endcase
    res.side = side;
    res.castle = castle;
    res.ep = passant;
    res.done = (phase == PH_DONE);
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned want_v, input int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t %s: expected %0d, got %0d", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $display("%0t unexpected result item: expected none, got piece %0d", $time,
                   piece_code);
          errors++;
        end else begin
          want = result_q.pop_front();
          check_field("piece_code", want.piece, piece_code);
          check_field("side_to_move", want.side, side_to_move);
          check_field("castling_rights", want.castle, castling_rights);
          check_field("en_passant_square", want.ep, en_passant_square);
          check_field("parse_done", want.done, parse_done);
        end
      end
      if (in_valid && in_ready) begin
        predicted = board_step(command, fen_char, square_index);
        result_q.push_back(row_typed ? row_want : predicted);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("fen_board_parser: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int run;
    int stall;
    int r;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      out_ready <= 1'b1;
      repeat (run) @(negedge clk);
      r = $urandom_range(0, 19);
      stall = (r < 14) ? $urandom_range(1, 3) : (r < 19) ? $urandom_range(4, 10)
                                                           : $urandom_range(20, 40);
      out_ready <= 1'b0;
      repeat (stall) @(negedge clk);
    end
  end

  task automatic put(input logic [1:0] cmd, input logic [7:0] ch, input logic [6:0] sq);
    int gap;
    int r;
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) burst_left = $urandom_range(20, 80);
      else if (r < 55) gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else if (r < 98) gap = $urandom_range(4, 8);
      else gap = $urandom_range(15, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    fen_char <= ch;
    square_index <= sq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic feed(input logic [7:0] ch);
    put(CMD_FEED, ch, 7'($urandom));
  endtask

  function automatic void plan_row(input logic [1:0] cmd, input logic [7:0] ch,
                                   input logic [6:0] sq, input int reps, input logic typed,
                                   input board_result_t want_v);
    stim_row_t row;
    row.cmd = cmd;
    row.ch = ch;
    row.sq = sq;
    row.reps = reps;
    row.typed = typed;
    row.want = want_v;
    plan.push_back(row);
  endfunction

  task automatic send_position();
    int left;
    int d;
    int r;
    put(CMD_START, 8'($urandom), 7'($urandom));
    for (int rank = 0; rank < 8; rank++) begin
      left = 8;
      while (left > 0) begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          feed(8'($urandom));
        end else if (r < 30) begin
          d = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 9) : $urandom_range(1, left);
          feed(8'("0" + d));
          left = (d >= left) ? 0 : left - d;
        end else begin
          feed(PIECE_CHARS[8*$urandom_range(0, 11) +: 8]);
          left--;
        end
      end
      if (rank < 7) feed("/");
    end
    feed(" ");
    r = $urandom_range(0, 99);
    feed((r < 45) ? "w" : (r < 90) ? "b" : 8'($urandom));
    feed(" ");
    if ($urandom_range(0, 3) == 0) begin
      feed("-");
    end else begin
      for (int k = 0; k < 4; k++) begin
        if ($urandom_range(0, 1) == 1) feed(CASTLE_CHARS[8*(3-k) +: 8]);
        if ($urandom_range(0, 9) == 0) feed(8'($urandom));
      end
    end
    feed(" ");
    r = $urandom_range(0, 99);
    if (r < 50) begin
      feed("-");
    end else if (r < 90) begin
      feed(8'("a" + $urandom_range(0, 7)));
      feed($urandom_range(0, 1) ? "3" : "6");
    end else begin
      feed(8'($urandom));
      feed(8'($urandom));
    end
    repeat ($urandom_range(0, 3)) feed(8'($urandom));
    repeat ($urandom_range(2, 10)) begin
      if ($urandom_range(0, 6) == 0) put(CMD_READ, 8'($urandom), 7'($urandom));
      else put(CMD_READ, 8'($urandom), {3'($urandom), 1'b0, 3'($urandom)});
    end
  endtask

  task automatic send_noise();
    int r;
    repeat ($urandom_range(3, 20)) begin
      r = $urandom_range(0, 99);
      if (r < 60) put(CMD_FEED, 8'($urandom), 7'($urandom));
      else if (r < 80) put(CMD_READ, 8'($urandom), 7'($urandom));
      else if (r < 90) put(CMD_START, 8'($urandom), 7'($urandom));
      else put(CMD_SPARE, 8'($urandom), 7'($urandom));
    end
  endtask

  initial begin
    logic [3:0] back [8];
    int         plan_items;
    back = '{W_ROOK, W_KNIGHT, W_BISHOP, W_QUEEN, W_KING, W_BISHOP, W_KNIGHT, W_ROOK};
    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_FEED;
    fen_char = '0;
    square_index = '0;
    row_typed = 1'b0;
    row_want = '0;
    errors = 0;
    items_sent = 0;
    burst_left = 0;
    idle_cycles = 0;

    for (int i = 0; i < 64; i++) board[i] = EMPTY;
    for (int c = 0; c < 8; c++) begin
      board[c] = back[c] + B_OFFSET;
      board[8 + c] = B_PAWN;
      board[48 + c] = W_PAWN;
      board[56 + c] = back[c];
    end
    filled = '0;
    phase = PH_DONE;
    side = SIDE_WHITE;
    castle = CASTLE_ALL;
    passant = NO_SQUARE;
    pfile = '0;

    // opening position reads, idle-phase items, then one short string end to end
    plan_row(CMD_READ, 8'h00, 7'h00, 1, 1'b1, {W_ROOK + B_OFFSET, AT_RESET});
    plan_row(CMD_READ, 8'hff, 7'h74, 1, 1'b1, {W_KING, AT_RESET});
    plan_row(CMD_READ, 8'h55, 7'h7f, 1, 1'b1, {OFF_BOARD, AT_RESET});
    plan_row(CMD_SPARE, 8'hff, 7'h08, 1, 1'b1, {EMPTY, AT_RESET});
    plan_row(CMD_FEED, "q", 7'h2a, 1, 1'b1, {EMPTY, AT_RESET});
    plan_row(CMD_START, 8'h00, 7'h00, 1, 1'b1, {EMPTY, SIDE_UNSET, 4'h0, NO_SQUARE, 1'b0});
    plan_row(CMD_FEED, "Z", 7'h00, 1, 1'b0, '0);
    plan_row(CMD_FEED, "k", 7'h7f, 1, 1'b0, '0);
    plan_row(CMD_FEED, 8'hff, 7'h00, 1, 1'b0, '0);
    plan_row(CMD_FEED, "/", 7'h00, 1, 1'b0, '0);
    plan_row(CMD_FEED, "9", 7'h00, 7, 1'b0, '0);
    plan_row(CMD_FEED, 8'h00, 7'h00, 1, 1'b0, '0);
    plan_row(CMD_FEED, "b", 7'h00, 1, 1'b0, '0);
    plan_row(CMD_FEED, "K", 7'h00, 1, 1'b0, '0);
    plan_row(CMD_FEED, "q", 7'h00, 1, 1'b0, '0);
    plan_row(CMD_FEED, "x", 7'h00, 1, 1'b0, '0);
    plan_row(CMD_FEED, " ", 7'h00, 1, 1'b0, '0);
    plan_row(CMD_FEED, "h", 7'h00, 1, 1'b0, '0);
    plan_row(CMD_FEED, "3", 7'h00, 1, 1'b0, '0);
    plan_row(CMD_READ, 8'h00, 7'h01, 1, 1'b0, '0);
    plan_row(CMD_READ, 8'h00, 7'h00, 1, 1'b0, '0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[k]) begin
      row_typed = plan[k].typed;
      row_want = plan[k].want;
      repeat (plan[k].reps) put(plan[k].cmd, plan[k].ch, plan[k].sq);
    end
    row_typed = 1'b0;
    plan_items = items_sent;

    while (items_sent < plan_items + RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) != 0) send_position();
      else send_noise();
    end
    in_valid <= 1'b0;

    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && result_q.size() == 0) begin
      $display("fen_board_parser: match");
    end else begin
      $display("fen_board_parser: mismatch");
    end
    $finish;
  end

endmodule

@@ fen_board_parser.f @@
hdl/fbp_pkg.sv
hdl/fbp_board_store.sv
hdl/fen_board_parser.sv
hdl/fbp_checker.sv
test/tb_top.sv
